// ----- src/lba_chs_block_read_retry_top_macros.svh -----
// Assertion macros for the block read retry back end.
`ifndef LBA_CHS_BLOCK_READ_RETRY_TOP_MACROS_SVH
`define LBA_CHS_BLOCK_READ_RETRY_TOP_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define LCBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define LCBR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/lcbr_pkg.sv -----
// Shared types and constants of the block read retry engine.
`timescale 1ns / 1ps
package lcbr_pkg;

  localparam int SPT_W = 6;
  localparam int SPC_W = 14;
  localparam int CNT_W = 7;
  localparam int DRV_W = 7;
  localparam int CFG_W = 14;
  localparam int PHASE_W = 3;

  localparam logic [15:0]        READ_OPCODE         = 16'h0200;
  localparam logic [7:0]         CYL_HIGH_MASK       = 8'hC0;
  localparam logic [7:0]         CORRECTED_STATUS    = 8'h11;
  localparam logic [PHASE_W-1:0] FAILURES_PER_SHRINK = 3'd5;
  localparam logic [7:0]         DRV_CODE_OFFSET     = 8'h80;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_FLUSH    = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SPT = 2'd0,
    CFG_SPC = 2'd1,
    CFG_BB  = 2'd2,
    CFG_DRV = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACT_HIT       = 3'd0,
    ACT_READ_CMD  = 3'd1,
    ACT_RESET_CMD = 3'd2,
    ACT_DONE      = 3'd3,
    ACT_FAILED    = 3'd4,
    ACT_FLUSHED   = 3'd5,
    ACT_BUSY      = 3'd6
  } action_e;

  // Classified request as it travels from the front to the back.
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_OK      = 2'd1,
    OP_FAIL    = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] block_number;
    logic        carry_flag;
    logic [7:0]  disk_status;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [6:0]  buffer_offset;
    logic [15:0] command_ax;
    logic [15:0] command_cx;
    logic [15:0] command_dx;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] blk;
  } cmd_t;

  // Geometry and window settings with zero already mapped to one.
  typedef struct packed {
    logic [SPT_W-1:0] spt;
    logic [SPC_W-1:0] spc;
    logic [CNT_W-1:0] bb;
    logic [DRV_W-1:0] drv;
  } cfg_t;

endpackage

// ----- src/lcbr_front.sv -----
// Front end: classifies incoming requests and queues them for the back end.
`timescale 1ns / 1ps
module lcbr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lcbr_pkg::in_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output lcbr_pkg::cmd_t     cmd_o
);
  import lcbr_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep, wr_en, rd_en;
  cmd_t       cmd_in;

  always_comb begin
    keep       = 1'b1;
    cmd_in.blk = item_i.block_number;
    cmd_in.op  = OP_READ;
    unique case (item_i.kind)
      KIND_READ:     cmd_in.op = OP_READ;
      KIND_COMPLETE: begin
        if (!item_i.carry_flag || item_i.disk_status == CORRECTED_STATUS) begin
          cmd_in.op = OP_OK;
        end else begin
          cmd_in.op = OP_FAIL;
        end
      end
      KIND_FLUSH:    cmd_in.op = OP_FLUSH;
      default:       keep = 1'b0;
    endcase
  end

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_q];
  // Requests of the unused kind are taken and dropped here.
  assign wr_en   = push_i && !full_o && keep;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_en ? ~wr_q : wr_q;
    rd_d  = rd_en ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

// ----- src/lcbr_outq.sv -----
// Two-entry result queue between the back end and the result ports.
`timescale 1ns / 1ps
module lcbr_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lcbr_pkg::out_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output lcbr_pkg::out_item_t item_o
);
  import lcbr_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_en ? ~wr_q : wr_q;
    rd_d  = rd_en ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- src/lcbr_div.sv -----
// Restoring divider that retires two quotient bits per cycle.
`timescale 1ns / 1ps
module lcbr_div #(
  parameter int DIV_W  = 32,
  parameter int STEP_W = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIV_W-1:0]          dividend_i,
  input  logic [lcbr_pkg::SPC_W-1:0] divisor_i,
  input  logic [STEP_W-1:0]         steps_i,
  output logic                      done_o,
  output logic [DIV_W-1:0]          quotient_o,
  output logic [lcbr_pkg::SPC_W-1:0] remainder_o
);
  import lcbr_pkg::*;

  logic [SPC_W-1:0]  rem_q, rem_d, dvs_q;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [SPC_W:0]    r1, s1, r2, s2;
  logic              q1, q2;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    r1    = {rem_q, dq_q[DIV_W-1]};
    q1    = (r1 >= {1'b0, dvs_q});
    s1    = q1 ? (r1 - {1'b0, dvs_q}) : r1;
    r2    = {s1[SPC_W-1:0], dq_q[DIV_W-2]};
    q2    = (r2 >= {1'b0, dvs_q});
    s2    = q2 ? (r2 - {1'b0, dvs_q}) : r2;
    rem_d = s2[SPC_W-1:0];
    dq_d  = {dq_q[DIV_W-3:0], q1, q2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule

// ----- src/lcbr_back.sv -----
// Back end: window state, disk geometry split, retry control and result staging.
`timescale 1ns / 1ps
`include "lba_chs_block_read_retry_top_macros.svh"
module lcbr_back #(
  parameter int BLK_W  = 32,
  parameter int DIV_W  = 32,
  parameter int STEP_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcbr_pkg::cfg_t      cfg_i,
  input  logic                cmd_empty_i,
  input  lcbr_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output lcbr_pkg::out_item_t res_o
);
  import lcbr_pkg::*;

  localparam int FULL_STEPS = DIV_W / 2;
  localparam int HEAD_STEPS = SPC_W / 2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CYL  = 5'b00010,
    ST_SEC  = 5'b00100,
    ST_HEAD = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [BLK_W-1:0]   win_start_q, win_start_d;
  logic [CNT_W-1:0]   win_cnt_q, win_cnt_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               waiting_q, waiting_d;
  logic [15:0]        pend_cx_q, pend_cx_d, pend_dx_q, pend_dx_d;
  out_item_t          res_a_q, res_a_d, res_b_q, res_b_d;
  logic               has_b_q, has_b_d;
  logic [DIV_W-1:0]   blk_q, blk_d;
  logic [9:0]         cyl_q, cyl_d;
  logic [SPC_W-1:0]   rem1_q, rem1_d;
  logic [SPT_W-1:0]   sec_q, sec_d;

  logic [BLK_W-1:0]   blk, diff;
  logic               hit;
  logic [PHASE_W-1:0] phase_inc;
  logic               shrink;
  logic [CNT_W-1:0]   cnt_dec, cnt_new;
  logic [SPT_W-1:0]   sector;
  logic [7:0]         head;
  logic [15:0]        new_cx, new_dx;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic [SPC_W-1:0]   div_divisor, div_rem;
  logic [STEP_W-1:0]  div_steps;

  function automatic out_item_t mk_res(action_e act, logic [CNT_W-1:0] off,
                                       logic [15:0] ax, logic [15:0] cx,
                                       logic [15:0] dx, logic lst);
    out_item_t r;
    r.action        = act;
    r.buffer_offset = off;
    r.command_ax    = ax;
    r.command_cx    = cx;
    r.command_dx    = dx;
    r.last          = lst;
    return r;
  endfunction

  lcbr_div #(
    .DIV_W  (DIV_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .steps_i     (div_steps),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    blk  = cmd_i.blk[BLK_W-1:0];
    diff = blk - win_start_q;
    hit  = (blk >= win_start_q) &&
           (diff < {{(BLK_W-CNT_W){1'b0}}, win_cnt_q});

    // Every fifth failed completion shortens the transfer by one block.
    phase_inc = phase_q + 1'b1;
    shrink    = (phase_inc >= FAILURES_PER_SHRINK);
    cnt_dec   = (win_cnt_q != '0) ? (win_cnt_q - 1'b1) : '0;
    cnt_new   = shrink ? cnt_dec : win_cnt_q;

    head   = div_quo[7:0];
    sector = sec_q + 1'b1;
    new_cx = {cyl_q[7:0], (({cyl_q[9:8], 6'b0} & CYL_HIGH_MASK) | {2'b0, sector})};
    new_dx = {head, DRV_CODE_OFFSET + {1'b0, cfg_i.drv}};
  end

  always_comb begin
    state_d      = state_q;
    win_start_d  = win_start_q;
    win_cnt_d    = win_cnt_q;
    phase_d      = phase_q;
    waiting_d    = waiting_q;
    pend_cx_d    = pend_cx_q;
    pend_dx_d    = pend_dx_q;
    res_a_d      = res_a_q;
    res_b_d      = res_b_q;
    has_b_d      = has_b_q;
    blk_d        = blk_q;
    cyl_d        = cyl_q;
    rem1_d       = rem1_q;
    sec_d        = sec_q;
    div_start    = 1'b0;
    div_dividend = blk_q;
    div_divisor  = {{(SPC_W-SPT_W){1'b0}}, cfg_i.spt};
    div_steps    = STEP_W'(FULL_STEPS);
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_READ: begin
              if (waiting_q) begin
                res_a_d = mk_res(ACT_BUSY, '0, '0, '0, '0, 1'b1);
                state_d = ST_EMIT;
              end else if (hit) begin
                res_a_d = mk_res(ACT_HIT, diff[CNT_W-1:0], '0, '0, '0, 1'b1);
                state_d = ST_EMIT;
              end else begin
                win_start_d  = blk;
                win_cnt_d    = cfg_i.bb;
                phase_d      = '0;
                blk_d        = DIV_W'(blk);
                div_start    = 1'b1;
                div_dividend = DIV_W'(blk);
                div_divisor  = cfg_i.spc;
                state_d      = ST_CYL;
              end
            end
            OP_OK: begin
              if (waiting_q) begin
                waiting_d = 1'b0;
                res_a_d   = mk_res(ACT_DONE, '0, '0, '0, '0, 1'b1);
                state_d   = ST_EMIT;
              end
            end
            OP_FAIL: begin
              if (waiting_q) begin
                res_a_d   = mk_res(ACT_RESET_CMD, '0, '0, pend_cx_q, pend_dx_q, 1'b0);
                has_b_d   = 1'b1;
                phase_d   = shrink ? '0 : phase_inc;
                win_cnt_d = cnt_new;
                if (cnt_new == '0) begin
                  waiting_d = 1'b0;
                  res_b_d   = mk_res(ACT_FAILED, '0, '0, '0, '0, 1'b1);
                end else begin
                  res_b_d = mk_res(ACT_READ_CMD, '0, READ_OPCODE | {9'b0, cnt_new},
                                   pend_cx_q, pend_dx_q, 1'b1);
                end
                state_d = ST_EMIT;
              end
            end
            OP_FLUSH: begin
              if (waiting_q) begin
                res_a_d = mk_res(ACT_BUSY, '0, '0, '0, '0, 1'b1);
              end else begin
                win_cnt_d = '0;
                res_a_d   = mk_res(ACT_FLUSHED, '0, '0, '0, '0, 1'b1);
              end
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_CYL: begin
        if (div_done) begin
          cyl_d     = div_quo[9:0];
          rem1_d    = div_rem;
          div_start = 1'b1;
          state_d   = ST_SEC;
        end
      end
      ST_SEC: begin
        if (div_done) begin
          // The head division runs on the first remainder, left-aligned.
          sec_d        = div_rem[SPT_W-1:0];
          div_start    = 1'b1;
          div_dividend = {rem1_q, {(DIV_W-SPC_W){1'b0}}};
          div_steps    = STEP_W'(HEAD_STEPS);
          state_d      = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (div_done) begin
          pend_cx_d = new_cx;
          pend_dx_d = new_dx;
          waiting_d = 1'b1;
          res_a_d   = mk_res(ACT_READ_CMD, '0, READ_OPCODE | {9'b0, win_cnt_q},
                             new_cx, new_dx, 1'b1);
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_push_o = 1'b1;
        if (!res_full_i) begin
          if (has_b_q) begin
            res_a_d = res_b_q;
            has_b_d = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_start_q <= '0;
      win_cnt_q   <= '0;
      phase_q     <= '0;
      waiting_q   <= 1'b0;
      pend_cx_q   <= '0;
      pend_dx_q   <= '0;
      has_b_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_start_q <= win_start_d;
      win_cnt_q   <= win_cnt_d;
      phase_q     <= phase_d;
      waiting_q   <= waiting_d;
      pend_cx_q   <= pend_cx_d;
      pend_dx_q   <= pend_dx_d;
      has_b_q     <= has_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_a_q <= res_a_d;
    res_b_q <= res_b_d;
    blk_q   <= blk_d;
    cyl_q   <= cyl_d;
    rem1_q  <= rem1_d;
    sec_q   <= sec_d;
  end

  `LCBR_ASSERT(a_wait_has_window, waiting_q |-> (win_cnt_q != '0), "Outstanding read with empty window")
  `LCBR_ASSERT_IMPL(a_div_done_state, div_done, (state_q == ST_CYL || state_q == ST_SEC || state_q == ST_HEAD), "Divider finished outside a division step")
  `LCBR_ASSERT_IMPL(a_hit_in_window, (state_q == ST_EMIT && res_a_q.action == ACT_HIT), (res_a_q.buffer_offset < win_cnt_q), "Hit offset lies outside the window")

endmodule

// ----- src/lba_chs_block_read_retry_top.sv -----
// Top level of the block read retry engine: configuration registers and queues.
// Hit, busy, flush and done results are staged in a result register and then the result queue;
// the back end takes no new request until its results are queued (two for a failed completion).
// A miss first runs three divider passes: cylinder, sector and head.
// Reset (asynchronous, active low) empties both queues and the window and loads 63 sectors,
// 16065 sectors per cylinder and 32 blocks into the geometry registers.
`timescale 1ns / 1ps
module lba_chs_block_read_retry_top #(
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  lcbr_pkg::in_item_t            in_item_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output lcbr_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [lcbr_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import lcbr_pkg::*;

  localparam int BLK_W  = (ADDRESS_WIDTH < 32) ? ADDRESS_WIDTH : 32;
  localparam int DIV_W  = BLK_W + (BLK_W % 2);
  localparam int STEP_W = $clog2(DIV_W / 2 + 1);

  logic [SPT_W-1:0] spt_q;
  logic [SPC_W-1:0] spc_q;
  logic [CNT_W-1:0] bb_q;
  logic [DRV_W-1:0] drv_q;
  cfg_t             cfg;

  logic      cmd_empty, cmd_pop, res_full, res_push;
  cmd_t      cmd;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q <= SPT_W'(63);
      spc_q <= SPC_W'(16065);
      bb_q  <= CNT_W'(32);
      drv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPT: spt_q <= cfg_wdata_i[SPT_W-1:0];
        CFG_SPC: spc_q <= cfg_wdata_i[SPC_W-1:0];
        CFG_BB:  bb_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_DRV: drv_q <= cfg_wdata_i[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero geometry or window length behaves as one.
  always_comb begin
    cfg.spt = (spt_q == '0) ? SPT_W'(1) : spt_q;
    cfg.spc = (spc_q == '0) ? SPC_W'(1) : spc_q;
    cfg.bb  = (bb_q == '0) ? CNT_W'(1) : bb_q;
    cfg.drv = drv_q;
  end

  lcbr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd)
  );

  lcbr_back #(
    .BLK_W  (BLK_W),
    .DIV_W  (DIV_W),
    .STEP_W (STEP_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  lcbr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (out_item_o)
  );

endmodule

// ----- tb/sv/tb_lba_chs_block_read_retry_top.sv -----
// Self-checking testbench for the block read retry engine: directed table, then random phases.
`timescale 1ns / 1ps
module tb_lba_chs_block_read_retry_top;
  import lcbr_pkg::*;

  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS = 135;
  localparam int NUM_PHASES = 9;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  in_item_t         in_item_i = '0;
  logic             full;
  logic             empty;
  logic             pop = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = CFG_SPT;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // Shadow copy of the registers and of the window and retry state.
  logic [5:0]  cfg_spt;
  logic [13:0] cfg_spc;
  logic [6:0]  cfg_bb;
  logic [6:0]  cfg_drv;
  logic [31:0] win_start;
  logic [6:0]  win_count;
  logic [2:0]  fail_phase;
  bit          disk_busy;
  logic [15:0] pend_cx;
  logic [15:0] pend_dx;

  out_item_t pred_res[2];
  int        pred_n;
  out_item_t due_replies[$];
  dir_row_t  dir_rows[$];

  bit no_idle = 1'b0;
  int errors = 0;
  int requests_sent = 0;
  int requests_ignored = 0;
  int replies_checked = 0;
  int act_seen[7];

  always #4 clk_i = ~clk_i;

  lba_chs_block_read_retry_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Works out the replies to one request and advances the shadow state.
  task automatic predict_disk_read(input in_item_t r);
    logic [31:0] spt, spc, cyl, head, sector, packed_cx;
    logic [7:0]  drv_code;
    out_item_t   o;
    pred_n = 0;
    o = '0;
    o.last = 1'b1;
    case (r.kind)
      KIND_READ: begin
        if (disk_busy) begin
          o.action = ACT_BUSY;
        end else if (r.block_number >= win_start &&
                     (r.block_number - win_start) < {25'd0, win_count}) begin
          o.action = ACT_HIT;
          o.buffer_offset = 7'(r.block_number - win_start);
        end else begin
          spt = (cfg_spt == '0) ? 32'd1 : {26'd0, cfg_spt};
          spc = (cfg_spc == '0) ? 32'd1 : {18'd0, cfg_spc};
          win_start = r.block_number;
          win_count = (cfg_bb == '0) ? 7'd1 : cfg_bb;
          fail_phase = '0;
          cyl = r.block_number / spc;
          head = (r.block_number % spc) / spt;
          sector = (r.block_number % spt) + 32'd1;
          // Cylinder bits 9..8 land in bits 7..6 next to the sector.
          packed_cx = ({24'd0, cyl[7:0]} << 8) | ((cyl >> 2) & {24'd0, CYL_HIGH_MASK})
                      | sector;
          pend_cx = packed_cx[15:0];
          drv_code = {1'b0, cfg_drv} + DRV_CODE_OFFSET;
          pend_dx = {head[7:0], drv_code};
          disk_busy = 1'b1;
          o.action = ACT_READ_CMD;
          o.command_ax = READ_OPCODE | {9'd0, win_count};
          o.command_cx = pend_cx;
          o.command_dx = pend_dx;
        end
        pred_res[0] = o;
        pred_n = 1;
      end
      KIND_COMPLETE: begin
        if (disk_busy) begin
          if (!r.carry_flag || r.disk_status == CORRECTED_STATUS) begin
            disk_busy = 1'b0;
            o.action = ACT_DONE;
            pred_res[0] = o;
            pred_n = 1;
          end else begin
            o.action = ACT_RESET_CMD;
            o.command_cx = pend_cx;
            o.command_dx = pend_dx;
            o.last = 1'b0;
            pred_res[0] = o;
            o.last = 1'b1;
            fail_phase = fail_phase + 3'd1;
            if (fail_phase >= FAILURES_PER_SHRINK) begin
              fail_phase = '0;
              if (win_count != '0) win_count = win_count - 7'd1;
            end
            if (win_count == '0) begin
              disk_busy = 1'b0;
              o = '0;
              o.action = ACT_FAILED;
              o.last = 1'b1;
            end else begin
              o.action = ACT_READ_CMD;
              o.command_ax = READ_OPCODE | {9'd0, win_count};
            end
            pred_res[1] = o;
            pred_n = 2;
          end
        end
      end
      KIND_FLUSH: begin
        if (disk_busy) begin
          o.action = ACT_BUSY;
        end else begin
          win_count = '0;
          o.action = ACT_FLUSHED;
        end
        pred_res[0] = o;
        pred_n = 1;
      end
      default: ;
    endcase
  endtask

  function automatic out_item_t reply(input action_e a, input logic [6:0] off);
    out_item_t o;
    o = '0;
    o.action = a;
    o.buffer_offset = off;
    o.last = 1'b1;
    return o;
  endfunction

  task automatic add_row(input kind_e k, input logic [31:0] blk, input logic carry,
                         input logic [7:0] status, input bit typed, input out_item_t want);
    dir_row_t row;
    row.req.kind = k;
    row.req.block_number = blk;
    row.req.carry_flag = carry;
    row.req.disk_status = status;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Mostly well-formed traffic: misses, hits around the window and failing completions.
  function automatic in_item_t draw_request();
    in_item_t r;
    int       pick;
    r.kind = KIND_READ;
    r.block_number = $urandom;
    r.carry_flag = 1'($urandom);
    r.disk_status = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (disk_busy) begin
      if (pick < 75) begin
        r.kind = KIND_COMPLETE;
        r.carry_flag = ($urandom_range(0, 9) < 8);
        if ($urandom_range(0, 9) == 0) r.disk_status = CORRECTED_STATUS;
      end else if (pick < 85) begin
        r.kind = KIND_READ;
      end else if (pick < 93) begin
        r.kind = KIND_FLUSH;
      end else begin
        r.kind = KIND_UNUSED;
      end
    end else begin
      if (pick < 40 && win_count != '0) begin
        case ($urandom_range(0, 5))
          0: r.block_number = win_start + {25'd0, win_count};
          1: r.block_number = win_start - 32'd1;
          default: r.block_number = win_start + $urandom_range(0, int'(win_count) - 1);
        endcase
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0: r.block_number = $urandom;
          1: r.block_number = $urandom_range(0, 50000);
          default: r.block_number = 32'hFFFF_FFFF - $urandom_range(0, 500);
        endcase
      end else if (pick < 85) begin
        r.kind = KIND_FLUSH;
      end else if (pick < 95) begin
        r.kind = KIND_COMPLETE;
      end else begin
        r.kind = KIND_UNUSED;
      end
    end
    return r;
  endfunction

  // Push stays high across back-to-back requests; it only drops for a gap.
  task automatic send_request(input in_item_t req, input bit typed, input out_item_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (full !== 1'b0);
    if (req.kind == KIND_UNUSED || (req.kind == KIND_COMPLETE && !disk_busy))
      requests_ignored++;
    predict_disk_read(req);
    if (typed) begin
      due_replies.push_back(want);
    end else begin
      for (int i = 0; i < pred_n; i++) due_replies.push_back(pred_res[i]);
    end
    requests_sent++;
  endtask

  // Waits until every reply is in, then lets any ignored request drain.
  task automatic settle_block();
    push <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Upper data bits beyond the register width carry junk on purpose.
  task automatic write_reg(input cfg_idx_e idx, input logic [13:0] val);
    logic [CFG_W-1:0] data;
    case (idx)
      CFG_SPT: data = {8'($urandom), val[5:0]};
      CFG_SPC: data = val;
      default: data = {7'($urandom), val[6:0]};
    endcase
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SPT: cfg_spt = data[5:0];
      CFG_SPC: cfg_spc = data[13:0];
      CFG_BB:  cfg_bb = data[6:0];
      default: cfg_drv = data[6:0];
    endcase
  endtask

  task automatic write_setup(input int spt, input int spc, input int bb, input int drv);
    settle_block();
    write_reg(CFG_SPT, 14'(spt));
    write_reg(CFG_SPC, 14'(spc));
    write_reg(CFG_BB, 14'(bb));
    write_reg(CFG_DRV, 14'(drv));
    cfg_we_i <= 1'b0;
  endtask

  task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Reply side: random pop stalls, each accepted reply checked against the oldest expectation.
  initial begin
    int        stall;
    out_item_t got;
    out_item_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      got = out_item_o;
      if (int'(got.action) < 7) act_seen[int'(got.action)]++;
      if (due_replies.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = due_replies.pop_front();
        note_field("action", 16'(want.action), 16'(got.action));
        note_field("buffer_offset", 16'(want.buffer_offset), 16'(got.buffer_offset));
        note_field("command_ax", want.command_ax, got.command_ax);
        note_field("command_cx", want.command_cx, got.command_cx);
        note_field("command_dx", want.command_dx, got.command_dx);
        note_field("last", 16'(want.last), 16'(got.last));
        replies_checked++;
      end
    end
  end

  initial begin
    out_item_t none;
    out_item_t first_read;
    in_item_t  req;
    int        counted;
    int        spt_set[NUM_PHASES];
    int        spc_set[NUM_PHASES];
    int        bb_set[NUM_PHASES];
    int        drv_set[NUM_PHASES];

    cfg_spt = 6'd63;
    cfg_spc = 14'd16065;
    cfg_bb = 7'd32;
    cfg_drv = 7'd0;
    win_start = '0;
    win_count = '0;
    fail_phase = '0;
    disk_busy = 1'b0;
    pend_cx = '0;
    pend_dx = '0;
    foreach (act_seen[i]) act_seen[i] = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset geometry: 63 sectors, 16065 per cylinder, 32 blocks.
    none = '0;
    first_read = '{action: ACT_READ_CMD, buffer_offset: 7'd0, command_ax: 16'h0220,
                   command_cx: 16'h0001, command_dx: 16'h0080, last: 1'b1};
    add_row(KIND_COMPLETE, 32'd0, 1'b0, 8'h00, 1'b0, none);
    add_row(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, none);
    add_row(KIND_FLUSH, 32'd0, 1'b0, 8'h00, 1'b1, reply(ACT_FLUSHED, 7'd0));
    add_row(KIND_READ, 32'd0, 1'b0, 8'h00, 1'b1, first_read);
    add_row(KIND_READ, 32'd5, 1'b0, 8'h00, 1'b1, reply(ACT_BUSY, 7'd0));
    add_row(KIND_FLUSH, 32'd0, 1'b0, 8'h00, 1'b1, reply(ACT_BUSY, 7'd0));
    add_row(KIND_COMPLETE, 32'd0, 1'b0, 8'hFF, 1'b1, reply(ACT_DONE, 7'd0));
    add_row(KIND_READ, 32'd5, 1'b0, 8'h00, 1'b1, reply(ACT_HIT, 7'd5));
    add_row(KIND_READ, 32'd31, 1'b0, 8'h00, 1'b1, reply(ACT_HIT, 7'd31));
    add_row(KIND_READ, 32'd32, 1'b0, 8'h00, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b1, CORRECTED_STATUS, 1'b1, reply(ACT_DONE, 7'd0));
    add_row(KIND_READ, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, none);
    // Five failed completions in a row shrink the transfer by one block.
    add_row(KIND_COMPLETE, 32'd0, 1'b1, 8'h00, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b1, 8'hFF, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b1, 8'h10, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b1, 8'h80, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b1, 8'h01, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b0, 8'h00, 1'b1, reply(ACT_DONE, 7'd0));
    add_row(KIND_READ, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b1, reply(ACT_HIT, 7'd0));
    add_row(KIND_READ, 32'hFFFF_FFFE, 1'b0, 8'h00, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b0, CORRECTED_STATUS, 1'b1, reply(ACT_DONE, 7'd0));
    add_row(KIND_FLUSH, 32'd0, 1'b0, 8'h00, 1'b1, reply(ACT_FLUSHED, 7'd0));
    add_row(KIND_READ, 32'hFFFF_FFFE, 1'b0, 8'h00, 1'b0, none);
    add_row(KIND_COMPLETE, 32'd0, 1'b1, CORRECTED_STATUS, 1'b1, reply(ACT_DONE, 7'd0));
    add_row(KIND_COMPLETE, 32'd0, 1'b1, CORRECTED_STATUS, 1'b0, none);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Zero geometry and zero length first, then both extremes, then a few picks.
    spt_set = '{0, 1, 63, 17, 63, 0, 0, 0, 0};
    spc_set = '{0, 1, 16128, 68, 16065, 0, 0, 0, 0};
    bb_set  = '{0, 1, 127, 3, 2, 0, 0, 0, 0};
    drv_set = '{127, 0, 127, 32, 1, 0, 0, 0, 0};
    for (int p = 5; p < NUM_PHASES; p++) begin
      spt_set[p] = $urandom_range(1, 63);
      spc_set[p] = $urandom_range(1, 16383);
      bb_set[p] = $urandom_range(1, 6);
      drv_set[p] = $urandom_range(0, 127);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_setup(spt_set[p], spc_set[p], bb_set[p], drv_set[p]);
      no_idle = (p == 2 || p == 6);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        req = draw_request();
        if (!(req.kind == KIND_UNUSED || (req.kind == KIND_COMPLETE && !disk_busy)))
          counted++;
        send_request(req, 1'b0, none);
      end
    end
    no_idle = 1'b0;
    settle_block();

    $display("Sent %0d requests (%0d ignored) over %0d register settings; checked %0d replies.",
             requests_sent, requests_ignored, NUM_PHASES + 1, replies_checked);
    $display("Seen: %0d hits, %0d read commands, %0d retries, %0d done, %0d failed reads.",
             act_seen[ACT_HIT], act_seen[ACT_READ_CMD], act_seen[ACT_RESET_CMD],
             act_seen[ACT_DONE], act_seen[ACT_FAILED]);
    if (errors == 0 && due_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d replies outstanding.", due_replies.size());
    $display("status: fail");
    $finish;
  end

endmodule
